// ===== hdl/flsm_pkg.sv =====
// Shared types, command codes and saturating arithmetic for the frame latency monitor.
`default_nettype none
package flsm_pkg;

    localparam logic [2:0] CMD_STAGE  = 3'd0;
    localparam logic [2:0] CMD_FRAME  = 3'd1;
    localparam logic [2:0] CMD_INPUT  = 3'd2;
    localparam logic [2:0] CMD_FORGET = 3'd3;
    localparam logic [2:0] CMD_REPORT = 3'd4;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_IDLE_GAP = 2'd2;

    localparam logic        ENABLE_RESET   = 1'b1;
    localparam logic [31:0] INTERVAL_RESET = 32'd2000000;
    localparam logic [31:0] IDLE_GAP_RESET = 32'd250000;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  surface_slot;
        logic [1:0]  stage_index;
        logic [47:0] time_us;
        logic [47:0] start_time_us;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  out_slot;
        logic [2:0]  kind;
        logic [31:0] span_count;
        logic [47:0] span_total_us;
        logic [31:0] span_worst_us;
        logic [31:0] frames;
        logic [31:0] inputs_seen;
        logic [31:0] idle_gaps;
        logic        last_item;
    } t_out_res;

    // queued operation: duration already worked out for stage records
    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  slot;
        logic [1:0]  stage;
        logic [47:0] time_us;
        logic [47:0] dur;
    } t_op;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (&v) ? v : v + 32'd1;
    endfunction

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add48 = s[48] ? {48{1'b1}} : s[47:0];
    endfunction

    function automatic logic [31:0] clip32(input logic [47:0] d);
        clip32 = (|d[47:32]) ? {32{1'b1}} : d[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/frame_latency_stats_monitor.sv =====
// Top level: configuration registers, front end, queue and statistics back end.
//
// Request channel i_valid/o_stall carries one command (stage record, frame,
// input event, forget, report) with its timestamps in i_req. Result channel
// o_valid/i_stall carries t_out_res records produced by reports only.
// Configuration: i_cfg_we with i_cfg_index (0 enable, 1 report interval,
// 2 idle gap) and i_cfg_data; write only while the block is idle.
// A two-entry queue sits between the front end and the back end; the front
// end stalls only when it is full.
// Event commands pass two back-end states (table read, then update); the back
// end takes the next command from the queue only once it is idle again.
// A report that acts walks every slot: an inactive slot is passed over in
// S_WALK_SLOT, an active one visits S_WALK_SLOT and then S_WALK_STAGE for each
// stage, and a final S_FLUSH step marks the last result. Each result waits
// as pending until a later result or the flush step moves it to the output.
// Reset clears all statistics, the last report time and the queue, and sets
// the registers to enable 1, interval 2000000 us, idle gap 250000 us.
// When the receiver stalls, the result register holds and, with one pending, the walk waits.
`default_nettype none
module frame_latency_stats_monitor #(
    parameter int SURFACES = 8,
    parameter int STAGES   = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire flsm_pkg::t_in_req  i_req,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output flsm_pkg::t_out_res      o_res,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    logic          r_enable;
    logic [31:0]   r_interval;
    logic [31:0]   r_idle_gap;
    logic          w_q_valid;
    flsm_pkg::t_op w_q_op;
    logic          w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= flsm_pkg::ENABLE_RESET;
            r_interval <= flsm_pkg::INTERVAL_RESET;
            r_idle_gap <= flsm_pkg::IDLE_GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                flsm_pkg::REG_ENABLE:   r_enable   <= i_cfg_data[0];
                flsm_pkg::REG_INTERVAL: r_interval <= i_cfg_data;
                flsm_pkg::REG_IDLE_GAP: r_idle_gap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    flsm_front #(.SURFACES(SURFACES), .STAGES(STAGES)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_req     (i_req),
        .i_enable  (r_enable),
        .o_q_valid (w_q_valid),
        .o_q_op    (w_q_op),
        .i_q_pop   (w_q_pop)
    );

    flsm_back #(.SURFACES(SURFACES), .STAGES(STAGES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_op     (w_q_op),
        .o_q_pop    (w_q_pop),
        .i_interval (r_interval),
        .i_idle_gap (r_idle_gap),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res)
    );

endmodule
`default_nettype wire

// ===== hdl/flsm_front.sv =====
// Front end: accepts requests, drops ones without effect, queues the rest.
`default_nettype none
module flsm_front #(
    parameter int SURFACES = 8,
    parameter int STAGES   = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire flsm_pkg::t_in_req i_req,
    input  wire logic             i_enable,
    output logic                  o_q_valid,
    output flsm_pkg::t_op         o_q_op,
    input  wire logic             i_q_pop
);

    flsm_pkg::t_op r_q [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          w_accept;
    logic          w_keep;
    logic          w_push;
    flsm_pkg::t_op w_op;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_accept  = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_op    = r_q[r_rd];

    always_comb begin
        w_keep = 1'b0;
        if (i_enable) begin
            if (i_req.command == flsm_pkg::CMD_REPORT) begin
                w_keep = 1'b1;
            end else if (32'(i_req.surface_slot) < SURFACES) begin
                case (i_req.command) inside
                    flsm_pkg::CMD_STAGE: w_keep = (32'(i_req.stage_index) < STAGES);
                    flsm_pkg::CMD_FRAME, flsm_pkg::CMD_INPUT, flsm_pkg::CMD_FORGET:
                        w_keep = 1'b1;
                    default: w_keep = 1'b0;
                endcase
            end
        end
    end

    assign w_push = w_accept && w_keep;

    always_comb begin
        w_op.cmd     = i_req.command;
        w_op.slot    = i_req.surface_slot;
        w_op.stage   = i_req.stage_index;
        w_op.time_us = i_req.time_us;
        // clamp negative durations to zero
        w_op.dur     = (i_req.time_us >= i_req.start_time_us) ?
                       i_req.time_us - i_req.start_time_us : 48'd0;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_op;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !w_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_cnt != 2'd0)) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== hdl/flsm_back.sv =====
// Back end: statistics tables, per-request update and the report walk.
`default_nettype none
module flsm_back #(
    parameter int SURFACES = 8,
    parameter int STAGES   = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire flsm_pkg::t_op     i_q_op,
    output logic                   o_q_pop,
    input  wire logic [31:0]       i_interval,
    input  wire logic [31:0]       i_idle_gap,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output flsm_pkg::t_out_res     o_res
);

    localparam int SLW = (SURFACES > 1) ? $clog2(SURFACES) : 1;
    localparam int NE  = SURFACES * STAGES;
    localparam int EW  = (NE > 1) ? $clog2(NE) : 1;
    localparam int STW = (STAGES > 1) ? $clog2(STAGES) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_WALK_SLOT, S_WALK_STAGE, S_FLUSH
    } t_state;

    t_state r_state;

    logic [31:0] r_scnt [NE];
    logic [47:0] r_stot [NE];
    logic [31:0] r_swst [NE];
    logic [31:0] r_gcnt [SURFACES];
    logic [47:0] r_gtot [SURFACES];
    logic [31:0] r_gwst [SURFACES];
    logic [31:0] r_fcnt [SURFACES];
    logic [31:0] r_icnt [SURFACES];
    logic [31:0] r_idle [SURFACES];
    logic [47:0] r_lft  [SURFACES];
    logic [SURFACES-1:0] r_lfv;
    logic [SURFACES-1:0] r_act;
    logic [47:0] r_lrt;

    flsm_pkg::t_op r_op;
    logic [SLW-1:0] r_sl;
    logic [EW-1:0]  r_ent;
    logic [31:0]    r_rd_cnt;
    logic [47:0]    r_rd_tot;
    logic [31:0]    r_rd_wst;
    logic [47:0]    r_dur;

    logic [SLW-1:0] r_walk_slot;
    logic [STW-1:0] r_walk_stage;
    flsm_pkg::t_out_res r_pend;
    logic               r_pend_v;
    flsm_pkg::t_out_res r_out;
    logic               r_out_v;

    logic [SLW-1:0] w_q_slot;
    logic [EW-1:0]  w_q_ent;
    logic [EW-1:0]  w_walk_ent;
    logic [31:0]    n_cnt;
    logic [47:0]    n_tot;
    logic [31:0]    n_wst;
    logic           w_can;
    logic           w_last_slot;
    logic           w_last_stage;
    logic           w_rep_go;
    logic           w_out_load;
    flsm_pkg::t_out_res w_sum_res;
    flsm_pkg::t_out_res w_stg_res;
    flsm_pkg::t_out_res w_fin_res;

    assign w_q_slot     = SLW'(i_q_op.slot);
    assign w_q_ent      = EW'(int'(i_q_op.slot) * STAGES + int'(i_q_op.stage));
    assign w_walk_ent   = EW'(int'(r_walk_slot) * STAGES + int'(r_walk_stage));
    assign w_last_slot  = (r_walk_slot == SLW'(SURFACES - 1));
    assign w_last_stage = (r_walk_stage == STW'(STAGES - 1));
    assign o_q_pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_valid      = r_out_v;
    assign o_res        = r_out;
    // a new result fits when the pending one can move to the output register
    assign w_can        = !r_pend_v || !r_out_v || !i_stall;
    assign w_rep_go     = (r_dur >= 48'(i_interval));

    always_comb begin
        n_cnt = flsm_pkg::sat_inc32(r_rd_cnt);
        n_tot = flsm_pkg::sat_add48(r_rd_tot, r_dur);
        n_wst = (flsm_pkg::clip32(r_dur) > r_rd_wst) ? flsm_pkg::clip32(r_dur) : r_rd_wst;
    end

    always_comb begin
        w_sum_res.out_slot      = 3'(r_walk_slot);
        w_sum_res.kind          = 3'd0;
        w_sum_res.span_count    = r_gcnt[r_walk_slot];
        w_sum_res.span_total_us = r_gtot[r_walk_slot];
        w_sum_res.span_worst_us = r_gwst[r_walk_slot];
        w_sum_res.frames        = r_fcnt[r_walk_slot];
        w_sum_res.inputs_seen   = r_icnt[r_walk_slot];
        w_sum_res.idle_gaps     = r_idle[r_walk_slot];
        w_sum_res.last_item     = 1'b0;
        w_stg_res.out_slot      = 3'(r_walk_slot);
        w_stg_res.kind          = 3'(int'(r_walk_stage) + 1);
        w_stg_res.span_count    = r_scnt[w_walk_ent];
        w_stg_res.span_total_us = r_stot[w_walk_ent];
        w_stg_res.span_worst_us = r_swst[w_walk_ent];
        w_stg_res.frames        = 32'd0;
        w_stg_res.inputs_seen   = 32'd0;
        w_stg_res.idle_gaps     = 32'd0;
        w_stg_res.last_item     = 1'b0;
        w_fin_res               = r_pend;
        w_fin_res.last_item     = 1'b1;
    end

    // load the output register from the pending result
    always_comb begin
        case (r_state)
            S_WALK_SLOT:  w_out_load = r_act[r_walk_slot] && w_can && r_pend_v;
            S_WALK_STAGE: w_out_load = (r_scnt[w_walk_ent] != 32'd0) && w_can;
            S_FLUSH:      w_out_load = r_pend_v && (!r_out_v || !i_stall);
            default:      w_out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_lfv    <= '0;
            r_act    <= '0;
            r_lrt    <= 48'd0;
            for (int i = 0; i < NE; i++) begin
                r_scnt[i] <= 32'd0;
                r_stot[i] <= 48'd0;
                r_swst[i] <= 32'd0;
            end
            for (int i = 0; i < SURFACES; i++) begin
                r_gcnt[i] <= 32'd0;
                r_gtot[i] <= 48'd0;
                r_gwst[i] <= 32'd0;
                r_fcnt[i] <= 32'd0;
                r_icnt[i] <= 32'd0;
                r_idle[i] <= 32'd0;
                r_lft[i]  <= 48'd0;
            end
        end else begin
            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_stall) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_op  <= i_q_op;
                        r_sl  <= w_q_slot;
                        r_ent <= w_q_ent;
                        if (i_q_op.cmd == flsm_pkg::CMD_STAGE) begin
                            r_rd_cnt <= r_scnt[w_q_ent];
                            r_rd_tot <= r_stot[w_q_ent];
                            r_rd_wst <= r_swst[w_q_ent];
                            r_dur    <= i_q_op.dur;
                        end else begin
                            r_rd_cnt <= r_gcnt[w_q_slot];
                            r_rd_tot <= r_gtot[w_q_slot];
                            r_rd_wst <= r_gwst[w_q_slot];
                            if (i_q_op.cmd == flsm_pkg::CMD_REPORT) begin
                                r_dur <= i_q_op.time_us - r_lrt;
                            end else begin
                                r_dur <= (i_q_op.time_us >= r_lft[w_q_slot]) ?
                                         i_q_op.time_us - r_lft[w_q_slot] : 48'd0;
                            end
                        end
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_op.cmd == flsm_pkg::CMD_REPORT && w_rep_go) begin
                        r_state <= S_WALK_SLOT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                    case (r_op.cmd)
                        flsm_pkg::CMD_STAGE: begin
                            r_scnt[r_ent] <= n_cnt;
                            r_stot[r_ent] <= n_tot;
                            r_swst[r_ent] <= n_wst;
                            r_act[r_sl]   <= 1'b1;
                        end
                        flsm_pkg::CMD_FRAME: begin
                            if (r_lfv[r_sl]) begin
                                if (r_dur > 48'(i_idle_gap)) begin
                                    r_idle[r_sl] <= flsm_pkg::sat_inc32(r_idle[r_sl]);
                                end else begin
                                    r_gcnt[r_sl] <= n_cnt;
                                    r_gtot[r_sl] <= n_tot;
                                    r_gwst[r_sl] <= n_wst;
                                end
                            end
                            r_lft[r_sl]  <= r_op.time_us;
                            r_lfv[r_sl]  <= 1'b1;
                            r_fcnt[r_sl] <= flsm_pkg::sat_inc32(r_fcnt[r_sl]);
                            r_act[r_sl]  <= 1'b1;
                        end
                        flsm_pkg::CMD_INPUT: begin
                            r_icnt[r_sl] <= flsm_pkg::sat_inc32(r_icnt[r_sl]);
                            r_act[r_sl]  <= 1'b1;
                        end
                        flsm_pkg::CMD_FORGET: begin
                            for (int j = 0; j < STAGES; j++) begin
                                r_scnt[EW'(int'(r_sl) * STAGES + j)] <= 32'd0;
                                r_stot[EW'(int'(r_sl) * STAGES + j)] <= 48'd0;
                                r_swst[EW'(int'(r_sl) * STAGES + j)] <= 32'd0;
                            end
                            r_gcnt[r_sl] <= 32'd0;
                            r_gtot[r_sl] <= 48'd0;
                            r_gwst[r_sl] <= 32'd0;
                            r_fcnt[r_sl] <= 32'd0;
                            r_icnt[r_sl] <= 32'd0;
                            r_idle[r_sl] <= 32'd0;
                            r_lft[r_sl]  <= 48'd0;
                            r_lfv[r_sl]  <= 1'b0;
                            r_act[r_sl]  <= 1'b0;
                        end
                        flsm_pkg::CMD_REPORT: begin
                            if (w_rep_go) begin
                                r_lrt       <= r_op.time_us;
                                r_walk_slot <= '0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_WALK_SLOT: begin
                    if (!r_act[r_walk_slot]) begin
                        if (w_last_slot) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_walk_slot <= r_walk_slot + SLW'(1);
                        end
                    end else if (w_can) begin
                        // hold one result back so the final one can be marked
                        if (r_pend_v) begin
                            r_out <= r_pend;
                        end
                        r_pend       <= w_sum_res;
                        r_pend_v     <= 1'b1;
                        r_walk_stage <= '0;
                        r_state      <= S_WALK_STAGE;
                    end
                end
                S_WALK_STAGE: begin
                    if (r_scnt[w_walk_ent] == 32'd0 || w_can) begin
                        if (r_scnt[w_walk_ent] != 32'd0) begin
                            r_out    <= r_pend;
                            r_pend   <= w_stg_res;
                            r_pend_v <= 1'b1;
                        end
                        if (w_last_stage) begin
                            // clear the slot, keep its last frame time
                            for (int j = 0; j < STAGES; j++) begin
                                r_scnt[EW'(int'(r_walk_slot) * STAGES + j)] <= 32'd0;
                                r_stot[EW'(int'(r_walk_slot) * STAGES + j)] <= 48'd0;
                                r_swst[EW'(int'(r_walk_slot) * STAGES + j)] <= 32'd0;
                            end
                            r_gcnt[r_walk_slot] <= 32'd0;
                            r_gtot[r_walk_slot] <= 48'd0;
                            r_gwst[r_walk_slot] <= 32'd0;
                            r_fcnt[r_walk_slot] <= 32'd0;
                            r_icnt[r_walk_slot] <= 32'd0;
                            r_idle[r_walk_slot] <= 32'd0;
                            r_act[r_walk_slot]  <= 1'b0;
                            if (w_last_slot) begin
                                r_state <= S_FLUSH;
                            end else begin
                                r_walk_slot <= r_walk_slot + SLW'(1);
                                r_state     <= S_WALK_SLOT;
                            end
                        end else begin
                            r_walk_stage <= r_walk_stage + STW'(1);
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (!r_out_v || !i_stall) begin
                        r_out    <= w_fin_res;
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v) else $error("pending result left behind");
    a_event_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_op.cmd != flsm_pkg::CMD_REPORT) |=> (r_state == S_IDLE))
        else $error("event update did not finish");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid) else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== sim/tb_frame_latency_stats_monitor.sv =====
// Self-checking testbench for the frame latency statistics monitor.
`default_nettype none
module tb_frame_latency_stats_monitor;

    localparam int NSURF = 8;
    localparam int NSTG  = 4;
    localparam int HOLD_LEN = 400;
    localparam logic [47:0] M48 = {48{1'b1}};
    localparam logic [31:0] M32 = {32{1'b1}};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    flsm_pkg::t_in_req  i_req = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    flsm_pkg::t_out_res o_res;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    frame_latency_stats_monitor u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_res(o_res),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow statistics
    logic        sh_enable;
    logic [31:0] sh_interval, sh_idle;
    logic [31:0] st_cnt [NSURF*NSTG];
    logic [47:0] st_tot [NSURF*NSTG];
    logic [31:0] st_wst [NSURF*NSTG];
    logic [31:0] gp_cnt [NSURF], fr_cnt [NSURF], in_cnt [NSURF], id_cnt [NSURF];
    logic [47:0] gp_tot [NSURF], lf_time [NSURF];
    logic [31:0] gp_wst [NSURF];
    logic        lf_ok [NSURF];
    logic [47:0] last_rep;

    flsm_pkg::t_out_res report_q [$];
    int          errors = 0;
    int          idle_pct = 0, stall_pct = 0;
    logic        hold_go = 1'b0;
    int          hold_cycles = 0;
    logic [47:0] now_us = 48'd0;

    function automatic logic [31:0] inc_sat(input logic [31:0] v);
        return (v == M32) ? v : v + 32'd1;
    endfunction

    function automatic logic [47:0] add_sat(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? M48 : s[47:0];
    endfunction

    function automatic logic [31:0] worst_of(input logic [31:0] w, input logic [47:0] d);
        logic [31:0] c;
        c = (d > {16'd0, M32}) ? M32 : d[31:0];
        return (c > w) ? c : w;
    endfunction

    task automatic wipe_slot(input int s);
        for (int i = 0; i < NSTG; i++) begin
            st_cnt[s*NSTG+i] = '0; st_tot[s*NSTG+i] = '0; st_wst[s*NSTG+i] = '0;
        end
        gp_cnt[s] = '0; gp_tot[s] = '0; gp_wst[s] = '0;
        fr_cnt[s] = '0; in_cnt[s] = '0; id_cnt[s] = '0;
    endtask

    task automatic stats_reset();
        sh_enable = flsm_pkg::ENABLE_RESET;
        sh_interval = flsm_pkg::INTERVAL_RESET;
        sh_idle = flsm_pkg::IDLE_GAP_RESET;
        for (int s = 0; s < NSURF; s++) begin
            wipe_slot(s);
            lf_time[s] = '0; lf_ok[s] = 1'b0;
        end
        last_rep = '0;
    endtask

    task automatic stats_apply(input flsm_pkg::t_in_req r);
        int s, e, n0;
        logic [47:0] d;
        logic act;
        flsm_pkg::t_out_res o;
        if (!sh_enable) return;
        s = int'(r.surface_slot);
        case (r.command)
            flsm_pkg::CMD_REPORT: begin
                if (((r.time_us - last_rep) & M48) < {16'd0, sh_interval}) return;
                last_rep = r.time_us;
                n0 = report_q.size();
                for (int k = 0; k < NSURF; k++) begin
                    act = (fr_cnt[k] != 0) || (in_cnt[k] != 0);
                    for (int i = 0; i < NSTG; i++) if (st_cnt[k*NSTG+i] != 0) act = 1'b1;
                    if (!act) continue;
                    o = '0;
                    o.out_slot = 3'(k); o.kind = 3'd0; o.span_count = gp_cnt[k];
                    o.span_total_us = gp_tot[k]; o.span_worst_us = gp_wst[k];
                    o.frames = fr_cnt[k]; o.inputs_seen = in_cnt[k]; o.idle_gaps = id_cnt[k];
                    report_q.push_back(o);
                    for (int i = 0; i < NSTG; i++) begin
                        e = k*NSTG+i;
                        if (st_cnt[e] == 0) continue;
                        o = '0;
                        o.out_slot = 3'(k); o.kind = 3'(i + 1); o.span_count = st_cnt[e];
                        o.span_total_us = st_tot[e]; o.span_worst_us = st_wst[e];
                        report_q.push_back(o);
                    end
                    wipe_slot(k);
                end
                if (report_q.size() > n0) report_q[$].last_item = 1'b1;
            end
            flsm_pkg::CMD_STAGE: begin
                e = s*NSTG + int'(r.stage_index);
                d = (r.time_us >= r.start_time_us) ? r.time_us - r.start_time_us : '0;
                st_cnt[e] = inc_sat(st_cnt[e]);
                st_tot[e] = add_sat(st_tot[e], d);
                st_wst[e] = worst_of(st_wst[e], d);
            end
            flsm_pkg::CMD_FRAME: begin
                if (lf_ok[s]) begin
                    d = (r.time_us >= lf_time[s]) ? r.time_us - lf_time[s] : '0;
                    if (d > {16'd0, sh_idle}) id_cnt[s] = inc_sat(id_cnt[s]);
                    else begin
                        gp_cnt[s] = inc_sat(gp_cnt[s]);
                        gp_tot[s] = add_sat(gp_tot[s], d);
                        gp_wst[s] = worst_of(gp_wst[s], d);
                    end
                end
                lf_time[s] = r.time_us; lf_ok[s] = 1'b1;
                fr_cnt[s] = inc_sat(fr_cnt[s]);
            end
            flsm_pkg::CMD_INPUT: in_cnt[s] = inc_sat(in_cnt[s]);
            flsm_pkg::CMD_FORGET: begin
                wipe_slot(s); lf_time[s] = '0; lf_ok[s] = 1'b0;
            end
            default: ;
        endcase
    endtask

    // receiver: random stall, or a long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_go && hold_cycles < HOLD_LEN) begin
            hold_cycles <= hold_cycles + 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (report_q.size() == 0) begin
                $error("result with none expected: slot %0d kind %0d", o_res.out_slot,
                       o_res.kind);
                errors++;
            end else begin
                flsm_pkg::t_out_res x;
                x = report_q.pop_front();
                if (o_res.out_slot != x.out_slot) begin
                    $error("out_slot exp %0d got %0d", x.out_slot, o_res.out_slot); errors++;
                end
                if (o_res.kind != x.kind) begin
                    $error("kind exp %0d got %0d", x.kind, o_res.kind); errors++;
                end
                if (o_res.span_count != x.span_count) begin
                    $error("span_count exp %0d got %0d", x.span_count, o_res.span_count);
                    errors++;
                end
                if (o_res.span_total_us != x.span_total_us) begin
                    $error("span_total_us exp %0d got %0d", x.span_total_us,
                           o_res.span_total_us);
                    errors++;
                end
                if (o_res.span_worst_us != x.span_worst_us) begin
                    $error("span_worst_us exp %0d got %0d", x.span_worst_us,
                           o_res.span_worst_us);
                    errors++;
                end
                if (o_res.frames != x.frames) begin
                    $error("frames exp %0d got %0d", x.frames, o_res.frames); errors++;
                end
                if (o_res.inputs_seen != x.inputs_seen) begin
                    $error("inputs_seen exp %0d got %0d", x.inputs_seen, o_res.inputs_seen);
                    errors++;
                end
                if (o_res.idle_gaps != x.idle_gaps) begin
                    $error("idle_gaps exp %0d got %0d", x.idle_gaps, o_res.idle_gaps);
                    errors++;
                end
                if (o_res.last_item != x.last_item) begin
                    $error("last_item exp %0d got %0d", x.last_item, o_res.last_item);
                    errors++;
                end
            end
        end
    end

    // offer one request, hold it until accepted; valid stays up for the next one
    task automatic send_req(input flsm_pkg::t_in_req r);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req <= r;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        stats_apply(r);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            flsm_pkg::REG_ENABLE:   sh_enable = val[0];
            flsm_pkg::REG_INTERVAL: sh_interval = val;
            flsm_pkg::REG_IDLE_GAP: sh_idle = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // drop valid right after the last accept, then wait for the results
    task automatic drain();
        i_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic flsm_pkg::t_in_req mk(input logic [2:0] c, input logic [2:0] s,
                                             input logic [1:0] g, input logic [47:0] t,
                                             input logic [47:0] st);
        flsm_pkg::t_in_req r;
        r.command = c; r.surface_slot = s; r.stage_index = g;
        r.time_us = t; r.start_time_us = st;
        return r;
    endfunction

    function automatic flsm_pkg::t_in_req rand_req(input int well);
        flsm_pkg::t_in_req r;
        logic [47:0] t;
        int p;
        p = int'($urandom_range(99));
        now_us = now_us + 48'($urandom_range(400000));
        t = now_us;
        if (well == 0) begin
            r = mk(3'($urandom_range(7)), 3'($urandom_range(7)), 2'($urandom_range(3)),
                   48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
        end else if (p < 35)
            r = mk(flsm_pkg::CMD_STAGE, 3'($urandom_range(7)), 2'($urandom_range(3)), t,
                   t - 48'($urandom_range(30000)) +
                   (($urandom_range(9) == 0) ? 48'd50000 : 48'd0));
        else if (p < 65)
            r = mk(flsm_pkg::CMD_FRAME, 3'($urandom_range(7)), 2'd0, t,
                   48'({$urandom, $urandom}));
        else if (p < 80)
            r = mk(flsm_pkg::CMD_INPUT, 3'($urandom_range(7)), 2'($urandom_range(3)), t,
                   48'd0);
        else if (p < 84)
            r = mk(flsm_pkg::CMD_FORGET, 3'($urandom_range(7)), 2'd0, t, 48'd0);
        else
            r = mk(flsm_pkg::CMD_REPORT, 3'($urandom_range(7)), 2'($urandom_range(3)), t,
                   48'({$urandom, $urandom}));
        return r;
    endfunction

    typedef struct {
        flsm_pkg::t_in_req  req;
        logic               has_res;
        flsm_pkg::t_out_res res;
    } t_row;

    t_row dir_rows [$];

    initial begin
        t_row row;
        flsm_pkg::t_out_res o;
        stats_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first frame, negative gap, saturation of total, report emits
        row.has_res = 0; row.res = '0;
        row.req = mk(flsm_pkg::CMD_REPORT, 3'd0, 2'd0, 48'd5, '0);
        dir_rows.push_back(row); // too early
        row.req = mk(flsm_pkg::CMD_FRAME, 3'd0, 2'd0, 48'd1000, '0); dir_rows.push_back(row);
        row.req = mk(flsm_pkg::CMD_FRAME, 3'd0, 2'd0, 48'd500, '0);
        dir_rows.push_back(row); // negative gap
        row.req = mk(flsm_pkg::CMD_FRAME, 3'd0, 2'd0, 48'd900000, '0);
        dir_rows.push_back(row); // idle
        row.req = mk(flsm_pkg::CMD_STAGE, 3'd7, 2'd3, M48, '0); dir_rows.push_back(row);
        row.req = mk(flsm_pkg::CMD_STAGE, 3'd7, 2'd3, M48, '0); dir_rows.push_back(row);
        row.req = mk(flsm_pkg::CMD_STAGE, 3'd7, 2'd0, 48'd10, 48'd20);
        dir_rows.push_back(row); // negative
        row.req = mk(flsm_pkg::CMD_INPUT, 3'd3, 2'd2, 48'd100, M48); dir_rows.push_back(row);
        row.req = mk(flsm_pkg::CMD_INPUT, 3'd4, 2'd1, 48'd100, '0); dir_rows.push_back(row);
        row.req = mk(flsm_pkg::CMD_FORGET, 3'd4, 2'd0, 48'd100, '0); dir_rows.push_back(row);
        row.req = mk(3'd5, 3'd1, 2'd0, 48'd100, '0); dir_rows.push_back(row);
        row.req = mk(3'd7, 3'd2, 2'd3, M48, M48); dir_rows.push_back(row);
        row.req = mk(flsm_pkg::CMD_REPORT, 3'd0, 2'd0, 48'd2000000, '0);
        dir_rows.push_back(row);
        for (int i = 0; i < dir_rows.size(); i++) send_req(dir_rows[i].req);
        drain();
        // typed-in check: slot 3 alone after a fresh report
        row.req = mk(flsm_pkg::CMD_INPUT, 3'd3, 2'd0, 48'd2000001, '0);
        send_req(row.req);
        o = '0; o.out_slot = 3'd3; o.inputs_seen = 32'd1; o.last_item = 1'b1;
        row.req = mk(flsm_pkg::CMD_REPORT, 3'd0, 2'd0, 48'd4000001, '0);
        send_req(row.req);
        if (report_q.size() != 1 || report_q[0] !== o) begin
            $error("report row: expected %p got %p", o, report_q.size() ? report_q[0] : '0);
            errors++;
        end
        drain();

        // extremes of the registers
        cfg_write(flsm_pkg::REG_INTERVAL, 32'd0);
        cfg_write(flsm_pkg::REG_IDLE_GAP, 32'd0);
        send_req(mk(flsm_pkg::CMD_FRAME, 3'd5, 2'd0, 48'd10, '0));
        send_req(mk(flsm_pkg::CMD_FRAME, 3'd5, 2'd0, 48'd10, '0));
        send_req(mk(flsm_pkg::CMD_FRAME, 3'd5, 2'd0, 48'd11, '0));
        send_req(mk(flsm_pkg::CMD_REPORT, 3'd0, 2'd0, 48'd11, '0));
        send_req(mk(flsm_pkg::CMD_REPORT, 3'd0, 2'd0, 48'd11, '0));
        drain();
        cfg_write(flsm_pkg::REG_ENABLE, 32'd0);
        send_req(mk(flsm_pkg::CMD_INPUT, 3'd1, 2'd0, 48'd12, '0));
        send_req(mk(flsm_pkg::CMD_REPORT, 3'd0, 2'd0, 48'd13, '0));
        drain();
        cfg_write(flsm_pkg::REG_ENABLE, 32'd1);
        cfg_write(flsm_pkg::REG_INTERVAL, M32);
        cfg_write(flsm_pkg::REG_IDLE_GAP, M32);
        send_req(mk(flsm_pkg::CMD_STAGE, 3'd2, 2'd1, 48'h0001_0000_0005, '0)); // worst clips
        send_req(mk(flsm_pkg::CMD_REPORT, 3'd0, 2'd0, 48'h0001_0000_0010, '0));
        drain();

        // random phases across settings and idling
        for (int ph = 0; ph < 6; ph++) begin
            idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? 68 : 0;
            stall_pct = (ph % 4 == 2) ? 68 : (ph % 4 == 3) ? 28 : 0;
            if (ph % 4 == 3) idle_pct = 28;
            cfg_write(flsm_pkg::REG_INTERVAL, (ph == 5) ? 32'd1 : $urandom_range(900000));
            cfg_write(flsm_pkg::REG_IDLE_GAP, (ph == 4) ? 32'd0 : $urandom_range(400000));
            if (ph == 2) hold_go = 1'b1;
            for (int n = 0; n < 52; n++) send_req(rand_req(int'($urandom_range(9) != 0)));
            now_us = now_us + 48'd5000000;
            send_req(mk(flsm_pkg::CMD_REPORT, 3'd0, 2'd0, now_us, '0));
            drain();
        end
        idle_pct = 0; stall_pct = 0;
        if (errors == 0) $display("tb_frame_latency_stats_monitor: PASS");
        else $display("tb_frame_latency_stats_monitor: FAIL");
        $finish;
    end

    initial begin
        #5000000;
        $display("tb_frame_latency_stats_monitor: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/flsm_pkg.sv
hdl/flsm_front.sv
hdl/flsm_back.sv
hdl/frame_latency_stats_monitor.sv
sim/tb_frame_latency_stats_monitor.sv
